// ===== src/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg: shared definitions for the rigid transform compose block
// Default number format, operand store layout and sequencer state types.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Default number format: signed Q8.24
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 24;

  // Operand store layout: R1 (0..8), p1 (9..11), R2 (12..20), p2 (21..23)
  localparam int NUM_WORDS = 24;
  localparam int ADDR_W    = $clog2(NUM_WORDS);

  localparam logic [ADDR_W-1:0] P1_BASE   = ADDR_W'(9);
  localparam logic [ADDR_W-1:0] R2_BASE   = ADDR_W'(12);
  localparam logic [ADDR_W-1:0] P2_BASE   = ADDR_W'(21);
  localparam logic [ADDR_W-1:0] LAST_LOAD = ADDR_W'(NUM_WORDS - 1);

  // Loop bounds of the 3x3 sequencer
  localparam logic [1:0] LAST_IDX  = 2'd2;
  localparam logic [1:0] TRANS_COL = 2'd3;

  // Top-level sequencer
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIFF_RD,
    ST_DIFF_WR,
    ST_MAC_RD,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_FIX_RD,
    ST_FIX,
    ST_EMIT
  } rtc_state_t;

  // Shared multiplier phases
  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_PP,
    MAC_RND
  } mac_state_t;

endpackage

// ===== src/rtc_in_if.sv =====
// ----------------------------------------------------------------------------
// rtc_in_if: input channel of the rigid transform compose block
// One transform word per item, with the mode bit sampled on the first word.
// ----------------------------------------------------------------------------
interface rtc_in_if #(
  parameter int VALUE_WIDTH = rtc_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] element;
  logic                          invert_first;

  modport source (output valid, element, invert_first, input ready);
  modport sink   (input valid, element, invert_first, output ready);
endinterface

// ===== src/rtc_out_if.sv =====
// ----------------------------------------------------------------------------
// rtc_out_if: result channel of the rigid transform compose block
// One result word per item; last_word marks the twelfth word.
// ----------------------------------------------------------------------------
interface rtc_out_if #(
  parameter int VALUE_WIDTH = rtc_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_element;
  logic                          last_word;

  modport source (output valid, result_element, last_word, input ready);
  modport sink   (input valid, result_element, last_word, output ready);
endinterface

// ===== src/rigid_transform_compose_core.sv =====
// ----------------------------------------------------------------------------
// rigid_transform_compose_core: composition of two rigid transforms
// Loads (R1,p1) then (R2,p2), 24 words, and returns R1*R2, p1+R1*p2, or in
// inverse mode R1^T*R2, R1^T*(p2-p1), as twelve signed fixed-point words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one transform word per item: rotation columns, then the
//          translation, first transform then second. invert_first is taken
//          with the first word of each pair and ignored on the others.
//   out_ch carries the twelve result words in the same layout; last_word
//          is set on the twelfth.
// Timing:
//   After the 24th word in_ch.ready stays low (both modes) while the 36
//   products run through one shared multiplier, one at a time, so the next
//   pair is taken only once the twelfth result word is in the output
//   register. In inverse mode the p2 - p1 differences are written before
//   the first product.
// Reset:
//   rst_n (synchronous, active low) empties the load count and the output
//   register; the operand store holds no defined data until loaded.
// Stalls:
//   The output register holds a word until taken; the sequencer waits only
//   when the next word is ready and the register is still full. Loading of
//   the next pair may start while the last word still waits.
// ----------------------------------------------------------------------------
module rigid_transform_compose_core #(
  parameter int VALUE_WIDTH   = rtc_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = rtc_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rtc_in_if.sink     in_ch,
  rtc_out_if.source  out_ch
);
  import rtc_pkg::*;

  localparam int W = VALUE_WIDTH;

  // Saturating add and subtract
  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] times3(logic [1:0] v);
    return ADDR_W'(v) + ADDR_W'({v, 1'b0});
  endfunction

  // Control state
  rtc_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] load_cnt_r, load_cnt_nxt;
  logic              mode_r, mode_nxt;
  logic [1:0]        i_r, i_nxt;       // row
  logic [1:0]        j_r, j_nxt;       // result column, 3 = translation
  logic [1:0]        k_r, k_nxt;       // dot-product term
  logic              out_valid_r, out_valid_nxt;

  // Payload
  logic signed [W-1:0] acc_r, acc_nxt;
  logic signed [W-1:0] out_data_r;
  logic                out_last_r;
  logic                out_load;

  // Operand store
  logic [W-1:0]        mem [NUM_WORDS];
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [W-1:0]        wr_data;
  logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr;
  logic signed [W-1:0] rd_a_r, rd_b_r;

  // Shared multiplier
  logic                mac_start;
  logic                mac_done;
  logic signed [W-1:0] mac_product;

  logic in_accept;
  logic out_free;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign mac_start   = (state_r == ST_MAC_GO);

  rtc_mac #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .op_a    (rd_a_r),
    .op_b    (rd_b_r),
    .done    (mac_done),
    .product (mac_product)
  );

  // Read addresses: left rotation entry (R1 or its transpose) and R2 or p2
  always_comb begin
    rd_a_addr = mode_r ? (ADDR_W'(k_r) + times3(i_r)) : (ADDR_W'(i_r) + times3(k_r));
    rd_b_addr = R2_BASE + ADDR_W'(k_r) + times3(j_r);
    unique case (state_r)
      ST_DIFF_RD, ST_DIFF_WR: begin
        rd_a_addr = P2_BASE + ADDR_W'(k_r);
        rd_b_addr = P1_BASE + ADDR_W'(k_r);
      end
      ST_FIX_RD, ST_FIX: begin
        rd_a_addr = P1_BASE + ADDR_W'(i_r);
      end
      default: begin
      end
    endcase
  end

  // Write port: loads, and p2 - p1 over p2 in inverse mode
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = load_cnt_r;
    wr_data = in_ch.element;
    if (state_r == ST_DIFF_WR) begin
      wr_en   = 1'b1;
      wr_addr = P2_BASE + ADDR_W'(k_r);
      wr_data = sat_sub(rd_a_r, rd_b_r);
    end else if (in_accept) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      mode_r      <= 1'b0;
      i_r         <= 2'd0;
      j_r         <= 2'd0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      mode_r      <= mode_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    mode_nxt      = mode_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          if (load_cnt_r == '0) begin
            mode_nxt = in_ch.invert_first;
          end
          if (load_cnt_r == LAST_LOAD) begin
            load_cnt_nxt = '0;
            state_nxt    = mode_r ? ST_DIFF_RD : ST_MAC_RD;
          end else begin
            load_cnt_nxt = load_cnt_r + ADDR_W'(1);
          end
        end
      end
      ST_DIFF_RD: state_nxt = ST_DIFF_WR;
      ST_DIFF_WR: begin
        if (k_r == LAST_IDX) begin
          k_nxt     = 2'd0;
          state_nxt = ST_MAC_RD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_DIFF_RD;
        end
      end
      ST_MAC_RD: begin
        if (k_r == 2'd0) begin
          acc_nxt = '0;
        end
        state_nxt = ST_MAC_GO;
      end
      ST_MAC_GO: state_nxt = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (mac_done) begin
          acc_nxt = sat_add(acc_r, mac_product);
          if (k_r == LAST_IDX) begin
            k_nxt     = 2'd0;
            state_nxt = (j_r == TRANS_COL && !mode_r) ? ST_FIX_RD : ST_EMIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_MAC_RD;
          end
        end
      end
      ST_FIX_RD: state_nxt = ST_FIX;
      ST_FIX: begin
        acc_nxt   = sat_add(rd_a_r, acc_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (i_r == LAST_IDX) begin
            i_nxt = 2'd0;
            if (j_r == TRANS_COL) begin
              j_nxt     = 2'd0;
              state_nxt = ST_LOAD;
            end else begin
              j_nxt     = j_r + 2'd1;
              state_nxt = ST_MAC_RD;
            end
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = ST_MAC_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Accumulator and output register
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (out_load) begin
      out_data_r <= acc_r;
      out_last_r <= (i_r == LAST_IDX) && (j_r == TRANS_COL);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_element = out_data_r;
  assign out_ch.last_word      = out_last_r;

`ifndef NO_ASSERTIONS
  // A product only completes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MAC_WAIT)
    else $error("multiplier result outside the wait state");

  // A new result item only comes from the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result item raised outside the emit step");

  // No item is taken while products are in flight
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> u_mac.state_r == MAC_IDLE && !mac_done)
    else $error("item accepted while the multiplier is busy");
`endif

endmodule

// ===== src/rtc_mac.sv =====
// ----------------------------------------------------------------------------
// rtc_mac: shared fixed-point multiplier
// Sign-magnitude product built from four half-width partial products, then
// rounded to nearest (ties away from zero) and saturated. Each product steps
// through capture, four partial products and round; done pulses after.
// ----------------------------------------------------------------------------
module rtc_mac #(
  parameter int VALUE_WIDTH   = rtc_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = rtc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] op_a,
  input  logic signed [VALUE_WIDTH-1:0] op_b,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] product
);
  import rtc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int H  = (W + 1) / 2;          // half width of a magnitude
  localparam int PW = 4 * H;                // product accumulator width
  localparam int RW = ((PW > FRACTION_BITS) ? PW : FRACTION_BITS) + 1;

  mac_state_t state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [W-1:0]      mag_a_r, mag_b_r;
  logic              neg_r;
  logic [PW-1:0]     prod_r;
  logic signed [W-1:0] product_r;

  // Partial product selection
  logic [2*H-1:0] ext_a, ext_b;
  logic [H-1:0]   half_a, half_b;
  logic [2*H-1:0] pp;
  logic [PW-1:0]  pp_shifted;

  assign ext_a  = (2*H)'(mag_a_r);
  assign ext_b  = (2*H)'(mag_b_r);
  assign half_a = cnt_r[0] ? ext_a[2*H-1:H] : ext_a[H-1:0];
  assign half_b = cnt_r[1] ? ext_b[2*H-1:H] : ext_b[H-1:0];
  assign pp     = half_a * half_b;

  always_comb begin
    unique case (cnt_r)
      2'd0:    pp_shifted = PW'(pp);
      2'd1,
      2'd2:    pp_shifted = PW'(pp) << H;
      default: pp_shifted = PW'(pp) << (2 * H);
    endcase
  end

  // Rounding and saturation of the magnitude
  logic [RW-1:0]   rnd, mag, limit;
  logic            sat;
  logic [W-1:0]    mag_w;
  logic signed [W-1:0] rounded;

  assign rnd   = RW'(prod_r) + (RW'(1) << (FRACTION_BITS - 1));
  assign mag   = rnd >> FRACTION_BITS;
  assign limit = RW'({1'b0, {(W-1){1'b1}}}) + RW'(neg_r);
  assign sat   = (mag >= limit);
  assign mag_w = mag[W-1:0];

  always_comb begin
    if (sat) begin
      rounded = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      rounded = neg_r ? W'(-mag_w) : mag_w;
    end
  end

  // Magnitudes of the operands
  logic [W-1:0] abs_a, abs_b;
  assign abs_a = op_a[W-1] ? W'(-op_a) : op_a;
  assign abs_b = op_b[W-1] ? W'(-op_b) : op_b;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MAC_IDLE;
      cnt_r   <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MAC_IDLE: begin
        if (start) begin
          state_nxt = MAC_PP;
          cnt_nxt   = 2'd0;
        end
      end
      MAC_PP: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = MAC_RND;
        end
      end
      MAC_RND: begin
        state_nxt = MAC_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = MAC_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == MAC_IDLE && start) begin
      mag_a_r <= abs_a;
      mag_b_r <= abs_b;
      neg_r   <= op_a[W-1] ^ op_b[W-1];
      prod_r  <= '0;
    end
    if (state_r == MAC_PP) begin
      prod_r <= prod_r + pp_shifted;
    end
    if (state_r == MAC_RND) begin
      product_r <= rounded;
    end
  end

  assign done    = done_r;
  assign product = product_r;

endmodule
